// ===== src/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg: shared definitions of the sorted value table
// Widths, command and status codes and the request record that passes from
// the front end through the queue to the table engine.
// ----------------------------------------------------------------------------
package svt_pkg;

   // Table size and the widths that follow from it.
   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // Field widths of the stream channels.
   localparam int VALUE_W       = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 40;

   // Command codes as carried on the request channel.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

   // Operation kinds after decoding in the front end.
   localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] OP_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] OP_DUMP   = 2'd2;
   localparam logic [CMD_W-1:0] OP_NOP    = 2'd3;

   // Status codes of a response.
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // Queue between the front end and the table engine.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CMD_W-1:0]   kind;
      logic [VALUE_W-1:0] value;
   } op_type;

endpackage

// ===== src/svt_front.sv =====
// ----------------------------------------------------------------------------
// svt_front: request decoder
// Takes requests from the input stream and turns the command into an
// operation kind for the table engine; unknown commands become no-ops.
// ----------------------------------------------------------------------------
module svt_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [svt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [svt_pkg::CMD_W-1:0]           req_tuser,
   output logic                                push,
   output svt_pkg::op_type                     push_op,
   input  logic                                queue_full
);

   logic [svt_pkg::CMD_W-1:0] kind;

   always_comb begin
      case (req_tuser)
         svt_pkg::CMD_INSERT: kind = svt_pkg::OP_INSERT;
         svt_pkg::CMD_DELETE: kind = svt_pkg::OP_DELETE;
         svt_pkg::CMD_DUMP:   kind = svt_pkg::OP_DUMP;
         default:             kind = svt_pkg::OP_NOP;
      endcase
   end

   assign req_tready    = !queue_full;
   assign push          = req_tvalid && !queue_full;
   assign push_op.kind  = kind;
   assign push_op.value = req_tdata[svt_pkg::VALUE_W-1:0];

endmodule

// ===== src/svt_queue.sv =====
// ----------------------------------------------------------------------------
// svt_queue: short operation queue
// A small first-in first-out buffer that lets the front end keep taking
// requests while the table engine is busy with a long scan.
// ----------------------------------------------------------------------------
module svt_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  svt_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output svt_pkg::op_type head_op
);

   svt_pkg::op_type               slot_ff [svt_pkg::QUEUE_DEPTH];
   logic [svt_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [svt_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [svt_pkg::QCNT_W-1:0]    fill_ff, fill_in;

   assign full      = (fill_ff == svt_pkg::QCNT_W'(svt_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_op   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== src/svt_back.sv =====
// ----------------------------------------------------------------------------
// svt_back: table engine
// Holds the sorted table and carries out insert, delete and dump one entry
// per cycle unless the response stream holds it up, through a single read
// and a single write port, and drives the registered response stream.
// ----------------------------------------------------------------------------
module svt_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 op_valid,
   input  svt_pkg::op_type                      op,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [svt_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [svt_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INS  = 2'd1;
   localparam logic [1:0] S_DEL  = 2'd2;
   localparam logic [1:0] S_DUMP = 2'd3;

   logic [svt_pkg::VALUE_W-1:0] entry_mem [svt_pkg::TABLE_DEPTH];

   logic [1:0]                     state_ff, state_in;
   logic [svt_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [svt_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                           found_ff, found_in;
   logic [svt_pkg::VALUE_W-1:0]    val_ff, val_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [svt_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [svt_pkg::VALUE_W-1:0]    rsp_value_ff;
   logic [svt_pkg::CNT_W-1:0]      rsp_count_ff;
   logic                           rsp_last_ff;

   logic                           out_free;
   logic                           emit;
   logic [svt_pkg::STATUS_W-1:0]   emit_status;
   logic [svt_pkg::VALUE_W-1:0]    emit_value;
   logic                           emit_last;

   logic                           wr_en;
   logic [svt_pkg::CNT_W-1:0]      wr_addr;
   logic [svt_pkg::VALUE_W-1:0]    wr_data;
   logic [svt_pkg::CNT_W-1:0]      rd_addr;
   logic [svt_pkg::VALUE_W-1:0]    rd_data_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Insert scans downwards from the top and reads the entry below the gap;
   // delete and dump scan upwards. The read address follows the next scan
   // position, so the registered read data belongs to the current one. No
   // scan step writes the entry that is read at the same edge.
   assign rd_addr = (state_in == S_INS) ? idx_in - 1'b1 : idx_in;

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr[svt_pkg::IDX_W-1:0]];
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      val_in      = val_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      emit_status = svt_pkg::ST_DONE;
      emit_value  = val_ff;
      emit_last   = 1'b1;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (op_valid && out_free) begin
               pop    = 1'b1;
               val_in = op.value;
               case (op.kind)
                  svt_pkg::OP_INSERT: begin
                     if (count_ff == svt_pkg::CNT_W'(svt_pkg::TABLE_DEPTH)) begin
                        emit        = 1'b1;
                        emit_status = svt_pkg::ST_FULL;
                        emit_value  = op.value;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS;
                     end
                  end
                  svt_pkg::OP_DELETE: begin
                     idx_in   = '0;
                     found_in = 1'b0;
                     state_in = S_DEL;
                  end
                  svt_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = svt_pkg::ST_EMPTY;
                        emit_value  = '0;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     emit       = 1'b1;
                     emit_value = op.value;
                  end
               endcase
            end
         end

         S_INS: begin
            if (idx_ff != '0 && !($signed(rd_data_ff) < $signed(val_ff))) begin
               // Entry below is not smaller: move it up one place.
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_ff;
               idx_in  = idx_ff - 1'b1;
            end else if (out_free) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = val_ff;
               count_in = count_ff + 1'b1;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_DEL: begin
            if (idx_ff != count_ff) begin
               if (found_ff) begin
                  // Close the gap left by the removed entry.
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - 1'b1;
                  wr_data = rd_data_ff;
               end else if (rd_data_ff == val_ff) begin
                  found_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  emit_status = svt_pkg::ST_NOT_FOUND;
               end
            end
         end

         S_DUMP: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_value = rd_data_ff;
               emit_last  = (idx_ff == count_ff - 1'b1);
               idx_in     = idx_ff + 1'b1;
               if (emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      val_ff   <= val_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_value_ff  <= emit_value;
         rsp_count_ff  <= count_in;
         rsp_last_ff   <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr[svt_pkg::IDX_W-1:0]] <= wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(svt_pkg::RSP_TDATA_W - svt_pkg::VALUE_W
                          - svt_pkg::COUNT_FIELD_W){1'b0}},
                        svt_pkg::COUNT_FIELD_W'(rsp_count_ff),
                        rsp_value_ff};

endmodule

// ===== src/sorted_value_table.sv =====
// ----------------------------------------------------------------------------
// sorted_value_table: bounded table of signed values kept in ascending order
// Stream block that inserts, deletes and dumps signed 32-bit values.
// ----------------------------------------------------------------------------
// The request stream carries a command in req_tuser (insert, delete or dump)
// and a signed value in req_tdata. Insert places the value in front of any equal
// values already stored; delete removes the first equal value; dump returns
// every stored value in ascending order, one response per entry, with
// rsp_tlast on the final one. Insert and delete, and the unused command
// code, each give exactly one response with rsp_tlast set.
// Each response carries a status in rsp_tuser and the value and the entry
// count after the operation in rsp_tdata.
// A front end decodes requests into a two-entry queue, so req_tready stays
// high while the table engine works, until that queue is full. The engine
// has one read and one write port on the table and visits one entry per
// cycle unless the response stream holds it up. Insert scans down from
// the top to its place, delete scans every stored entry, and a dump reads
// out each of them in turn. Each request passes through the queue and the
// engine, and its responses sit in an output register; while rsp_tready is
// low the engine waits at its next response and the queue fills up.
// Reset empties the table and the queue and drops rsp_tvalid; the table
// contents themselves are not cleared, only the entry count.
// ----------------------------------------------------------------------------
module sorted_value_table (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [svt_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [31:0] value
   input  logic [svt_pkg::CMD_W-1:0]         req_tuser,  // [1:0] cmd
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [svt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [31:0] result_value,
                                                         // [36:32] entry_count
   output logic [svt_pkg::STATUS_W-1:0]      rsp_tuser,  // [1:0] status
   output logic                              rsp_tlast
);

   logic            push;
   svt_pkg::op_type push_op;
   logic            queue_full;
   logic            pop;
   logic            queue_not_empty;
   svt_pkg::op_type head_op;

   // Front end: decodes each request and writes it into the queue.
   svt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_op    (push_op),
      .queue_full (queue_full)
   );

   // Queue that decouples request intake from the table scans.
   svt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_op   (head_op)
   );

   // Table engine with the registered response stage.
   svt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (queue_not_empty),
      .op         (head_op),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/sorted_value_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_table_test: self-checking bench for the sorted value table
// Drives insert, delete, dump and the unused command through the request
// stream. A scoreboard keeps its own sorted copy of the table, works out the
// responses that each accepted request should cause, and checks every
// response field by field as it arrives.
// ----------------------------------------------------------------------------
module sorted_value_table_test;

   // The request channel carries command code 3 too; the block treats it
   // as a no-operation that echoes the value.
   localparam logic [svt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Generous bound on the whole run, well above the slowest correct run.
   localparam int RUN_LIMIT_NS   = 3_000_000;
   localparam int RANDOM_ITEMS   = 105;
   localparam int DRAIN_CYCLES   = 4 * (svt_pkg::TABLE_DEPTH + 2);
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AFTER     = 60;

   // One response as the block should give it.
   typedef struct {
      logic [svt_pkg::STATUS_W-1:0]      status;
      logic [svt_pkg::VALUE_W-1:0]       value;
      logic [svt_pkg::COUNT_FIELD_W-1:0] entry_count;
      logic                              last;
   } table_response_type;

   // Scoreboard: a sorted copy of the table and the responses still owed.
   class value_table_scoreboard_type;
      logic signed [svt_pkg::VALUE_W-1:0] entries [svt_pkg::TABLE_DEPTH];
      int                                 count;
      table_response_type                 expected_responses [$];
      int                                 mismatches;
      int                                 responses_checked;

      function new();
         count             = 0;
         mismatches        = 0;
         responses_checked = 0;
      endfunction

      function logic signed [svt_pkg::VALUE_W-1:0] stored_value(input int idx);
         return entries[idx];
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("[%0t] error: %s", $realtime, what);
      endtask

      function void owe(input logic [svt_pkg::STATUS_W-1:0] status,
                        input logic [svt_pkg::VALUE_W-1:0] value, input logic last);
         table_response_type rsp;
         rsp.status      = status;
         rsp.value       = value;
         rsp.entry_count = count[svt_pkg::COUNT_FIELD_W-1:0];
         rsp.last        = last;
         expected_responses.push_back(rsp);
      endfunction

      // Applies one accepted request to the copy and queues its responses.
      function void note_request(input logic [svt_pkg::CMD_W-1:0] cmd,
                                 input logic signed [svt_pkg::VALUE_W-1:0] value);
         int pos;
         case (cmd)
            svt_pkg::CMD_INSERT: begin
               if (count >= svt_pkg::TABLE_DEPTH) begin
                  owe(svt_pkg::ST_FULL, value, 1'b1);
               end else begin
                  // The new value goes in front of the first entry that is
                  // not smaller.
                  pos = 0;
                  while (pos < count && entries[pos] < value)
                     pos++;
                  for (int i = count; i > pos; i--)
                     entries[i] = entries[i-1];
                  entries[pos] = value;
                  count++;
                  owe(svt_pkg::ST_DONE, value, 1'b1);
               end
            end
            svt_pkg::CMD_DELETE: begin
               pos = 0;
               while (pos < count && entries[pos] != value)
                  pos++;
               if (pos >= count) begin
                  owe(svt_pkg::ST_NOT_FOUND, value, 1'b1);
               end else begin
                  for (int i = pos; i + 1 < count; i++)
                     entries[i] = entries[i+1];
                  count--;
                  owe(svt_pkg::ST_DONE, value, 1'b1);
               end
            end
            svt_pkg::CMD_DUMP: begin
               if (count == 0) begin
                  owe(svt_pkg::ST_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++)
                     owe(svt_pkg::ST_DONE, entries[i], i + 1 == count);
               end
            end
            default: begin
               owe(svt_pkg::ST_DONE, value, 1'b1);
            end
         endcase
      endfunction

      task check_response(input logic [svt_pkg::STATUS_W-1:0] status,
                          input logic [svt_pkg::VALUE_W-1:0] value,
                          input logic [svt_pkg::COUNT_FIELD_W-1:0] entry_count,
                          input logic last);
         table_response_type want;
         responses_checked++;
         if (expected_responses.size() == 0) begin
            report_mismatch($sformatf("response with no request pending, value %0d",
                                      $signed(value)));
         end else begin
            want = expected_responses.pop_front();
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
            if (value !== want.value)
               report_mismatch($sformatf("value %0d, wanted %0d",
                                         $signed(value), $signed(want.value)));
            if (entry_count !== want.entry_count)
               report_mismatch($sformatf("entry count %0d, wanted %0d",
                                         entry_count, want.entry_count));
            if (last !== want.last)
               report_mismatch($sformatf("last %b, wanted %b", last, want.last));
         end
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [svt_pkg::REQ_TDATA_W-1:0]   req_tdata;   // [31:0] value
   logic [svt_pkg::CMD_W-1:0]         req_tuser;   // [1:0] cmd
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [svt_pkg::RSP_TDATA_W-1:0]   rsp_tdata;   // [31:0] result_value,
                                                   // [36:32] entry_count
   logic [svt_pkg::STATUS_W-1:0]      rsp_tuser;   // [1:0] status
   logic                              rsp_tlast;

   value_table_scoreboard_type table_model = new();

   // While set, neither side idles, so requests and responses run back to back.
   bit steady_stretch = 1'b0;

   sorted_value_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function int idle_gap();
      int roll;
      if (steady_stretch)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request, after an optional idle gap, and waits until the
   // block takes it. Sampling straight after the edge sees the values that
   // the block saw at that edge.
   task send_request(input logic [svt_pkg::CMD_W-1:0] cmd,
                     input logic signed [svt_pkg::VALUE_W-1:0] value);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      table_model.note_request(cmd, value);
   endtask

   // Most often values already stored, so that deletes hit and duplicates pile
   // up, then a narrow band around zero, then anything at all.
   function logic signed [svt_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40 && table_model.count > 0)
         return table_model.stored_value($urandom_range(0, table_model.count - 1));
      if (roll < 70)
         return $signed($urandom_range(0, 16)) - 8;
      return $urandom;
   endfunction

   // Random traffic that swings the table between empty and full: while
   // filling, inserts dominate; while draining, deletes do.
   task run_random_traffic(input int items);
      bit filling;
      int roll;
      logic [svt_pkg::CMD_W-1:0] cmd;
      filling = (table_model.count < svt_pkg::TABLE_DEPTH);
      for (int n = 0; n < items; n++) begin
         steady_stretch = (n >= 50 && n < 80);
         if (table_model.count >= svt_pkg::TABLE_DEPTH)
            filling = 1'b0;
         else if (table_model.count == 0)
            filling = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            cmd = CMD_UNUSED;
         else if (roll < 15)
            cmd = svt_pkg::CMD_DUMP;
         else if (roll < 73)
            cmd = filling ? svt_pkg::CMD_INSERT : svt_pkg::CMD_DELETE;
         else
            cmd = filling ? svt_pkg::CMD_DELETE : svt_pkg::CMD_INSERT;
         send_request(cmd, pick_value());
      end
      steady_stretch = 1'b0;
   endtask

   // Response side: checks every accepted response and stalls at random.
   // Once, part-way through, it holds off for a long stretch so that the
   // internal queue fills and the block stops taking requests.
   initial begin
      int stall_left;
      bit long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_tready     = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            table_model.check_response(rsp_tuser, rsp_tdata[svt_pkg::VALUE_W-1:0],
                                       rsp_tdata[svt_pkg::VALUE_W +: svt_pkg::COUNT_FIELD_W],
                                       rsp_tlast);
         if (!long_hold_done && table_model.responses_checked >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = idle_gap();
         end
      end
   end

   // Ends the run if it hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("sorted_value_table: mismatch");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = svt_pkg::CMD_INSERT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the empty cases first, then the value extremes,
      // duplicates and a dump, a miss and a hit on delete, the unused command,
      // and finally a table filled to the brim, one insert too many and a dump.
      send_request(svt_pkg::CMD_DUMP, 32'sd0);
      send_request(svt_pkg::CMD_DELETE, 32'sd7);
      send_request(svt_pkg::CMD_INSERT, 32'sd0);
      send_request(svt_pkg::CMD_INSERT, 32'sh8000_0000);
      send_request(svt_pkg::CMD_INSERT, 32'sh7fff_ffff);
      send_request(svt_pkg::CMD_INSERT, 32'sd0);
      send_request(svt_pkg::CMD_INSERT, -32'sd1);
      send_request(svt_pkg::CMD_DUMP, 32'sh7fff_ffff);
      send_request(svt_pkg::CMD_DELETE, 32'sd5);
      send_request(svt_pkg::CMD_DELETE, 32'sd0);
      send_request(CMD_UNUSED, 32'sh5555_aaaa);
      while (table_model.count < svt_pkg::TABLE_DEPTH)
         send_request(svt_pkg::CMD_INSERT, $signed($urandom_range(0, 6)) - 3);
      send_request(svt_pkg::CMD_INSERT, 32'sd1);
      send_request(svt_pkg::CMD_DUMP, 32'sd0);

      run_random_traffic(RANDOM_ITEMS);
      req_tvalid <= 1'b0;

      while (table_model.outstanding() > 0)
         @(posedge clock);
      // Anything that turns up now has no request behind it.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (table_model.outstanding() > 0)
         table_model.report_mismatch("responses still owed at the end");
      if (table_model.mismatches == 0)
         $display("sorted_value_table: match");
      else
         $display("sorted_value_table: mismatch");
      $finish;
   end

endmodule
